// ===== rtl/bffpa_pkg.sv =====
package bffpa_pkg;

  localparam int unsigned CNT_W      = 13;
  localparam int unsigned ADDR_W     = 32;
  localparam int unsigned PAGE_SHIFT = 12;
  localparam int unsigned VPN_W      = ADDR_W - PAGE_SHIFT;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_OOM       = 2'd1;
  localparam logic [1:0] ST_BAD_COUNT = 2'd2;

  typedef struct packed {
    logic              operation;
    logic [CNT_W-1:0]  page_count;
    logic [ADDR_W-1:0] address;
  } cmd_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [ADDR_W-1:0] address_res;
  } res_t;

endpackage

// ===== rtl/bitmap_first_fit_page_allocator_core.sv =====
// First-fit page allocator over a bitmap of HEAP_PAGES pages, one bit per page.
// A command word is taken on start when busy is low. Operation allocate scans
// the map from page 0 for the first run of page_count free pages, marks it used
// and returns heap_base plus the start page times 4096; operation free clears
// page_count bits from the page that the address names, ignoring pages beyond
// the heap. Each command gives one result word on res_o, marked by done_o for a
// single cycle; the receiver cannot stall, so no result waits.
// An allocate scan reads one 32-page map word per cycle from the map memory,
// then, after the setup and read states, updates the run one word per cycle.
// A free within the heap takes its own setup state, then the same read and
// update states. A zero-count allocate answers in the cycle after start.
// heap_base is written through the always-ready cfg channel; the user must write
// it only while idle, which the block does not enforce. After reset the block
// clears the map memory, one word per cycle, busy high; heap_base resets to 0.
module bitmap_first_fit_page_allocator_core #(
  parameter int unsigned HEAP_PAGES = 4096
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  bffpa_pkg::cmd_t                   cmd_i,
  output logic                              done_o,
  output bffpa_pkg::res_t                   res_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [bffpa_pkg::ADDR_W-1:0]      cfg_data_i
);

  localparam int unsigned MAP_WORDS = (HEAP_PAGES + 31) / 32;
  localparam int unsigned WW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int unsigned PGW       = WW + 5;
  localparam int unsigned RUNW      = PGW + 1;
  localparam int unsigned CMPW      = (RUNW > bffpa_pkg::CNT_W) ? RUNW : bffpa_pkg::CNT_W;
  localparam int unsigned LAST_VALID = HEAP_PAGES - (MAP_WORDS - 1) * 32;
  localparam logic [31:0] LAST_MASK = 32'hFFFF_FFFF >> (32 - LAST_VALID);
  localparam logic [WW-1:0] LAST_W  = WW'(MAP_WORDS - 1);
  localparam logic [PGW-1:0] LAST_PAGE = PGW'(HEAP_PAGES - 1);
  localparam logic [bffpa_pkg::VPN_W-1:0] HEAP_VPN = bffpa_pkg::VPN_W'(HEAP_PAGES);
  localparam logic [bffpa_pkg::VPN_W:0] LAST_VPN = (bffpa_pkg::VPN_W + 1)'(HEAP_PAGES - 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_A_SETUP,
    S_F_SETUP,
    S_MOD_RD,
    S_MOD_WR
  } state_e;

  state_e                          state_q;
  logic [WW-1:0]                   word_q;
  logic [RUNW-1:0]                 run_q;
  logic [PGW-1:0]                  lo_q;
  logic [PGW-1:0]                  hi_q;
  logic                            op_q;
  logic [bffpa_pkg::CNT_W-1:0]     cnt_q;
  logic [bffpa_pkg::ADDR_W-1:0]    diff_q;
  logic [bffpa_pkg::ADDR_W-1:0]    heap_base_q;
  logic                            done_q;
  bffpa_pkg::res_t                 res_q;

  logic [31:0]                     mem_q [2**WW];
  logic [31:0]                     rdata_q;
  logic                            mem_we;
  logic [WW-1:0]                   mem_waddr;
  logic [31:0]                     mem_wdata;
  logic [WW-1:0]                   mem_raddr;

  logic [31:0]                     free_v;
  logic [31:0]                     hit;
  logic                            any_hit;
  logic [4:0]                      hit_bit;
  logic [RUNW-1:0]                 run_out;

  logic [bffpa_pkg::VPN_W-1:0]     first_vpn;
  logic [bffpa_pkg::VPN_W:0]       end_vpn;
  logic [PGW-1:0]                  free_hi;
  logic [PGW-1:0]                  alloc_lo;

  logic [4:0]                      lo_bit;
  logic [4:0]                      hi_bit;
  logic [31:0]                     mask;
  logic [bffpa_pkg::ADDR_W-1:0]    start_addr;

  assign busy        = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign done_o      = done_q;
  assign res_o       = res_q;

  always_comb begin
    logic [RUNW-1:0] len;
    free_v = ~rdata_q & ((word_q == LAST_W) ? LAST_MASK : 32'hFFFF_FFFF);
    hit    = '0;
    run_out = '0;
    for (int i = 0; i < 32; i++) begin
      len = run_q + RUNW'(i + 1);
      for (int j = 0; j <= i; j++) begin
        if (!free_v[j]) begin
          len = RUNW'(i - j);
        end
      end
      hit[i] = (CMPW'(len) == CMPW'(cnt_q));
      if (i == 31) begin
        run_out = len;
      end
    end
    any_hit = |hit;
    hit_bit = '0;
    for (int i = 31; i >= 0; i--) begin
      if (hit[i]) begin
        hit_bit = 5'(i);
      end
    end
  end

  always_comb begin
    first_vpn = diff_q[bffpa_pkg::ADDR_W-1:bffpa_pkg::PAGE_SHIFT];
    end_vpn   = {1'b0, first_vpn} + (bffpa_pkg::VPN_W + 1)'(cnt_q)
                - (bffpa_pkg::VPN_W + 1)'(1);
    free_hi   = (end_vpn > LAST_VPN) ? LAST_PAGE : end_vpn[PGW-1:0];
    alloc_lo  = hi_q - PGW'(cnt_q) + PGW'(1);
  end

  always_comb begin
    lo_bit     = (word_q == lo_q[PGW-1:5]) ? lo_q[4:0] : 5'd0;
    hi_bit     = (word_q == hi_q[PGW-1:5]) ? hi_q[4:0] : 5'd31;
    mask       = (32'hFFFF_FFFF << lo_bit) & (32'hFFFF_FFFF >> (5'd31 - hi_bit));
    start_addr = heap_base_q + (bffpa_pkg::ADDR_W'(lo_q) << bffpa_pkg::PAGE_SHIFT);
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = word_q;
    mem_wdata = '0;
    mem_raddr = word_q;
    unique case (state_q)
      S_CLEAR: begin
        mem_we = 1'b1;
      end
      S_IDLE: begin
        mem_raddr = '0;
      end
      S_SCAN: begin
        mem_raddr = word_q + WW'(1);
      end
      S_MOD_WR: begin
        mem_we    = 1'b1;
        mem_wdata = (op_q == bffpa_pkg::OP_ALLOC) ? (rdata_q | mask) : (rdata_q & ~mask);
        mem_raddr = word_q + WW'(1);
      end
      default: begin
        mem_raddr = word_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem_q[mem_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      word_q      <= '0;
      run_q       <= '0;
      lo_q        <= '0;
      hi_q        <= '0;
      op_q        <= bffpa_pkg::OP_ALLOC;
      cnt_q       <= '0;
      diff_q      <= '0;
      heap_base_q <= '0;
      done_q      <= 1'b0;
      res_q       <= '0;
    end else begin
      done_q <= 1'b0;
      if (cfg_valid_i && cfg_ready_o) begin
        heap_base_q <= cfg_data_i;
      end
      unique case (state_q)
        S_CLEAR: begin
          if (word_q == LAST_W) begin
            word_q  <= '0;
            state_q <= S_IDLE;
          end else begin
            word_q <= word_q + WW'(1);
          end
        end
        S_IDLE: begin
          if (start) begin
            op_q   <= cmd_i.operation;
            cnt_q  <= cmd_i.page_count;
            diff_q <= {cmd_i.address[bffpa_pkg::ADDR_W-1:bffpa_pkg::PAGE_SHIFT],
                       bffpa_pkg::PAGE_SHIFT'(0)} - heap_base_q;
            word_q <= '0;
            run_q  <= '0;
            if (cmd_i.operation == bffpa_pkg::OP_FREE) begin
              state_q <= S_F_SETUP;
            end else if (cmd_i.page_count == '0) begin
              done_q  <= 1'b1;
              res_q   <= '{status: bffpa_pkg::ST_BAD_COUNT, address_res: '0};
            end else begin
              state_q <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (any_hit) begin
            hi_q    <= {word_q, hit_bit};
            state_q <= S_A_SETUP;
          end else if (word_q == LAST_W) begin
            done_q  <= 1'b1;
            res_q   <= '{status: bffpa_pkg::ST_OOM, address_res: '0};
            state_q <= S_IDLE;
          end else begin
            run_q  <= run_out;
            word_q <= word_q + WW'(1);
          end
        end
        S_A_SETUP: begin
          lo_q    <= alloc_lo;
          word_q  <= alloc_lo[PGW-1:5];
          state_q <= S_MOD_RD;
        end
        S_F_SETUP: begin
          if (cnt_q == '0 || first_vpn >= HEAP_VPN) begin
            done_q  <= 1'b1;
            res_q   <= '{status: bffpa_pkg::ST_OK, address_res: '0};
            state_q <= S_IDLE;
          end else begin
            lo_q    <= first_vpn[PGW-1:0];
            hi_q    <= free_hi;
            word_q  <= first_vpn[PGW-1:5];
            state_q <= S_MOD_RD;
          end
        end
        S_MOD_RD: begin
          state_q <= S_MOD_WR;
        end
        S_MOD_WR: begin
          if (word_q == hi_q[PGW-1:5]) begin
            done_q       <= 1'b1;
            res_q.status <= bffpa_pkg::ST_OK;
            res_q.address_res <= (op_q == bffpa_pkg::OP_ALLOC) ? start_addr : '0;
            word_q       <= '0;
            state_q      <= S_IDLE;
          end else begin
            word_q <= word_q + WW'(1);
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== tb/sv/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned HEAP_PAGES      = 4096;
  localparam int unsigned ITEMS_PER_PHASE = 125;
  localparam int unsigned NUM_PHASES      = 6;
  localparam logic [bffpa_pkg::ADDR_W-1:0] PAGE_MASK = 32'hFFFF_F000;

  typedef struct packed {
    logic            known;
    bffpa_pkg::cmd_t cmd;
    bffpa_pkg::res_t want;
  } dir_row_t;

  // Rows with known set carry their expected word; the rest take the predictor's.
  localparam dir_row_t DIR_TBL [25] = '{
    '{1'b1, '{bffpa_pkg::OP_ALLOC, 13'd0,    32'h0000_0000},
      '{bffpa_pkg::ST_BAD_COUNT, 32'h0000_0000}},
    '{1'b1, '{bffpa_pkg::OP_ALLOC, 13'd1,    32'hFFFF_FFFF},
      '{bffpa_pkg::ST_OK,        32'h0000_0000}},
    '{1'b1, '{bffpa_pkg::OP_ALLOC, 13'd3,    32'h0000_0000},
      '{bffpa_pkg::ST_OK,        32'h0000_1000}},
    '{1'b1, '{bffpa_pkg::OP_ALLOC, 13'd4097, 32'h0000_0000},
      '{bffpa_pkg::ST_OOM,       32'h0000_0000}},
    '{1'b1, '{bffpa_pkg::OP_ALLOC, 13'd8191, 32'h0000_0000},
      '{bffpa_pkg::ST_OOM,       32'h0000_0000}},
    '{1'b1, '{bffpa_pkg::OP_FREE,  13'd1,    32'h0000_1FFF},
      '{bffpa_pkg::ST_OK,        32'h0000_0000}},
    '{1'b1, '{bffpa_pkg::OP_ALLOC, 13'd1,    32'h0000_0000},
      '{bffpa_pkg::ST_OK,        32'h0000_1000}},
    '{1'b1, '{bffpa_pkg::OP_FREE,  13'd0,    32'h0000_3000},
      '{bffpa_pkg::ST_OK,        32'h0000_0000}},
    '{1'b1, '{bffpa_pkg::OP_FREE,  13'd5,    32'h0010_0000},
      '{bffpa_pkg::ST_OK,        32'h0000_0000}},
    '{1'b1, '{bffpa_pkg::OP_FREE,  13'd8191, 32'hFFFF_FFFF},
      '{bffpa_pkg::ST_OK,        32'h0000_0000}},
    '{1'b1, '{bffpa_pkg::OP_FREE,  13'd4096, 32'h0000_0000},
      '{bffpa_pkg::ST_OK,        32'h0000_0000}},
    '{1'b1, '{bffpa_pkg::OP_ALLOC, 13'd4096, 32'h0000_0000},
      '{bffpa_pkg::ST_OK,        32'h0000_0000}},
    '{1'b1, '{bffpa_pkg::OP_ALLOC, 13'd1,    32'h0000_0000},
      '{bffpa_pkg::ST_OOM,       32'h0000_0000}},
    '{1'b1, '{bffpa_pkg::OP_FREE,  13'd2,    32'h00FF_F000},
      '{bffpa_pkg::ST_OK,        32'h0000_0000}},
    '{1'b1, '{bffpa_pkg::OP_ALLOC, 13'd1,    32'h0000_0000},
      '{bffpa_pkg::ST_OK,        32'h00FF_F000}},
    '{1'b1, '{bffpa_pkg::OP_FREE,  13'd16,   32'h0000_8000},
      '{bffpa_pkg::ST_OK,        32'h0000_0000}},
    '{1'b1, '{bffpa_pkg::OP_ALLOC, 13'd17,   32'h0000_0000},
      '{bffpa_pkg::ST_OOM,       32'h0000_0000}},
    '{1'b1, '{bffpa_pkg::OP_ALLOC, 13'd16,   32'h0000_0000},
      '{bffpa_pkg::ST_OK,        32'h0000_8000}},
    '{1'b1, '{bffpa_pkg::OP_FREE,  13'd8191, 32'h0000_0000},
      '{bffpa_pkg::ST_OK,        32'h0000_0000}},
    '{1'b1, '{bffpa_pkg::OP_ALLOC, 13'd2,    32'h0000_0000},
      '{bffpa_pkg::ST_OK,        32'h0000_0000}},
    '{1'b1, '{bffpa_pkg::OP_FREE,  13'd1,    32'h0000_0000},
      '{bffpa_pkg::ST_OK,        32'h0000_0000}},
    '{1'b1, '{bffpa_pkg::OP_ALLOC, 13'd2,    32'h0000_0000},
      '{bffpa_pkg::ST_OK,        32'h0000_2000}},
    '{1'b1, '{bffpa_pkg::OP_ALLOC, 13'd1,    32'h0000_0000},
      '{bffpa_pkg::ST_OK,        32'h0000_0000}},
    '{1'b0, '{bffpa_pkg::OP_ALLOC, 13'd37,   32'h0000_0000},
      '{bffpa_pkg::ST_OK,        32'h0000_0000}},
    '{1'b0, '{bffpa_pkg::OP_FREE,  13'd37,   32'h0000_4000},
      '{bffpa_pkg::ST_OK,        32'h0000_0000}}
  };

  logic                         clk_i;
  logic                         rst_ni;
  logic                         start;
  logic                         busy;
  bffpa_pkg::cmd_t              cmd_i;
  logic                         done_o;
  bffpa_pkg::res_t              res_o;
  logic                         cfg_valid_i;
  logic                         cfg_ready_o;
  logic [bffpa_pkg::ADDR_W-1:0] cfg_data_i;

  logic [HEAP_PAGES-1:0]        page_used;
  logic [bffpa_pkg::ADDR_W-1:0] heap_base_q;
  bffpa_pkg::res_t              result_q [$];
  int unsigned                  run_first_q [$];
  int unsigned                  run_len_q [$];
  int unsigned                  n_err = 0;

  bitmap_first_fit_page_allocator_core #(
    .HEAP_PAGES(HEAP_PAGES)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .cmd_i      (cmd_i),
    .done_o     (done_o),
    .res_o      (res_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #(60_000_000);
    $display("bitmap_first_fit_page_allocator_core regression: fail");
    $finish;
  end

  task automatic alloc_or_free(input bffpa_pkg::cmd_t c, output bffpa_pkg::res_t r);
    int unsigned                  run;
    int unsigned                  first;
    logic [bffpa_pkg::ADDR_W-1:0] base_pg;
    logic [bffpa_pkg::ADDR_W-1:0] pg;
    run = 0;
    first = 0;
    r = '{bffpa_pkg::ST_OK, '0};
    if (c.operation == bffpa_pkg::OP_ALLOC) begin
      if (c.page_count == '0) begin
        r.status = bffpa_pkg::ST_BAD_COUNT;
      end else begin
        r.status = bffpa_pkg::ST_OOM;
        for (int unsigned p = 0; p < HEAP_PAGES; p++) begin
          if (page_used[p]) begin
            run = 0;
          end else begin
            if (run == 0) first = p;
            run++;
            if (run == c.page_count) begin
              for (int unsigned k = first; k <= p; k++) page_used[k] = 1'b1;
              r.status = bffpa_pkg::ST_OK;
              r.address_res = heap_base_q + (first << bffpa_pkg::PAGE_SHIFT);
              run_first_q.push_back(first);
              run_len_q.push_back(run);
              break;
            end
          end
        end
      end
    end else begin
      base_pg = ((c.address & PAGE_MASK) - heap_base_q) >> bffpa_pkg::PAGE_SHIFT;
      for (int unsigned k = 0; k < c.page_count; k++) begin
        pg = base_pg + k;
        if (pg >= base_pg && pg < HEAP_PAGES) page_used[pg] = 1'b0;
      end
    end
  endtask

  task automatic issue(input bffpa_pkg::cmd_t c, input logic known,
                       input bffpa_pkg::res_t want);
    bffpa_pkg::res_t r;
    start <= 1'b1;
    cmd_i <= c;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    alloc_or_free(c, r);
    result_q.push_back(known ? want : r);
  endtask

  task automatic sender_gap(input int unsigned pct);
    int unsigned len;
    if ($urandom_range(0, 99) < pct) begin
      len = $urandom_range(0, 1) ? $urandom_range(1, 4) : $urandom_range(5, 300);
      start <= 1'b0;
      repeat (len) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (result_q.size() != 0 || busy) @(posedge clk_i);
  endtask

  task automatic write_heap_base(input logic [bffpa_pkg::ADDR_W-1:0] v);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    heap_base_q = v;
    cfg_valid_i <= 1'b0;
  endtask

  task automatic random_cmd(output bffpa_pkg::cmd_t c);
    int unsigned sel;
    int unsigned idx;
    int unsigned len;
    c.operation  = bffpa_pkg::OP_ALLOC;
    c.address    = $urandom;
    c.page_count = '0;
    sel = $urandom_range(0, 99);
    if (sel < 45) begin
      sel = $urandom_range(0, 99);
      if (sel < 3) c.page_count = '0;
      else if (sel < 6) c.page_count = 13'($urandom_range(HEAP_PAGES + 1, 8191));
      else if (sel < 8) c.page_count = 13'(HEAP_PAGES);
      else if (sel < 20) c.page_count = 13'($urandom_range(65, 600));
      else c.page_count = 13'($urandom_range(1, 64));
    end else if (sel < 85 && run_first_q.size() != 0) begin
      idx = $urandom_range(0, run_first_q.size() - 1);
      len = run_len_q[idx];
      c.operation  = bffpa_pkg::OP_FREE;
      c.page_count = 13'(($urandom_range(0, 3) == 0) ? $urandom_range(1, len) : len);
      c.address    = heap_base_q + (run_first_q[idx] << bffpa_pkg::PAGE_SHIFT)
                     + $urandom_range(0, 4095);
      run_first_q.delete(idx);
      run_len_q.delete(idx);
    end else begin
      c.operation = bffpa_pkg::OP_FREE;
      sel = $urandom_range(0, 9);
      if (sel == 0) begin
        c.address    = heap_base_q + $urandom_range(0, 4095);
        c.page_count = $urandom_range(0, 1) ? 13'(HEAP_PAGES) : 13'd8191;
        run_first_q.delete();
        run_len_q.delete();
      end else if (sel < 5) begin
        c.page_count = 13'($urandom_range(0, 8191));
      end else begin
        c.address    = heap_base_q
                       + ($urandom_range(0, HEAP_PAGES + 64) << bffpa_pkg::PAGE_SHIFT)
                       + $urandom_range(0, 4095);
        c.page_count = 13'($urandom_range(0, 80));
      end
    end
  endtask

  always @(posedge clk_i) begin : check_results
    bffpa_pkg::res_t want;
    if (rst_ni && done_o) begin
      if (result_q.size() == 0) begin
        if (n_err < 10) begin
          $display("unexpected result word: status %0d address %h",
                   res_o.status, res_o.address_res);
        end
        n_err++;
      end else begin
        want = result_q.pop_front();
        if (res_o.status !== want.status || res_o.address_res !== want.address_res) begin
          if (n_err < 10) begin
            $display("result mismatch: status exp %0d got %0d, address exp %h got %h",
                     want.status, res_o.status, want.address_res, res_o.address_res);
          end
          n_err++;
        end
      end
    end
  end

  initial begin
    bffpa_pkg::cmd_t c;
    bffpa_pkg::res_t none;
    int unsigned     pct;
    none        = '{bffpa_pkg::ST_OK, '0};
    page_used   = '0;
    heap_base_q = '0;
    rst_ni      <= 1'b0;
    start       <= 1'b0;
    cmd_i       <= '0;
    cfg_valid_i <= 1'b0;
    cfg_data_i  <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    foreach (DIR_TBL[i]) issue(DIR_TBL[i].cmd, DIR_TBL[i].known, DIR_TBL[i].want);
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain();
      case (ph)
        0: write_heap_base(32'hFFFF_F000);
        1: write_heap_base($urandom);
        2: write_heap_base('0);
        3: write_heap_base($urandom & PAGE_MASK);
        4: write_heap_base(32'h7FFF_F123);
        default: write_heap_base($urandom);
      endcase
      pct = (ph < 2) ? 20 : (ph < 4) ? 48 : 0;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        sender_gap(pct);
        random_cmd(c);
        issue(c, 1'b0, none);
      end
    end
    drain();
    repeat (300) @(posedge clk_i);
    if (n_err == 0) begin
      $display("bitmap_first_fit_page_allocator_core regression: pass");
    end else begin
      $display("bitmap_first_fit_page_allocator_core regression: fail");
    end
    $finish;
  end

endmodule
